>>> rtl/mse_pkg.sv
// Package for the multi-stack engine: operation, stack and status codes,
// stack depths and the index widths derived from them.
// No dependencies; imported by every module of the block.
package mse_pkg;

  localparam int CALC_DEPTH = 25;
  localparam int OPER_DEPTH = 48;
  localparam int ARG_DEPTH  = 16;
  localparam int PARM_DEPTH = 16;

  localparam int CNT_W = 6;

  localparam int CALC_AW = (CALC_DEPTH > 1) ? $clog2(CALC_DEPTH) : 1;
  localparam int OPER_AW = (OPER_DEPTH > 1) ? $clog2(OPER_DEPTH) : 1;
  localparam int ARG_AW  = (ARG_DEPTH > 1)  ? $clog2(ARG_DEPTH)  : 1;
  localparam int PARM_AW = (PARM_DEPTH > 1) ? $clog2(PARM_DEPTH) : 1;

  localparam int TOK_W  = 8;
  localparam int VAL_W  = 32;
  localparam int CALC_W = TOK_W + VAL_W;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [2:0] {
    OP_CLEAR = 3'd0,
    OP_PUSH  = 3'd1,
    OP_POP   = 3'd2,
    OP_PEEK  = 3'd3,
    OP_EMPTY = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    SEL_CALC = 2'd0,
    SEL_OPER = 2'd1,
    SEL_ARG  = 2'd2,
    SEL_PARM = 2'd3
  } sel_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;  // capture the accepted input item
    logic exec;       // read top entry, write pushed entry, update fill count
    logic form;       // load the output register
  } cmd_t;

  function automatic cnt_t depth_of(input logic [1:0] sel);
    cnt_t d;
    case (sel)
      SEL_CALC: d = CNT_W'(CALC_DEPTH);
      SEL_OPER: d = CNT_W'(OPER_DEPTH);
      SEL_ARG:  d = CNT_W'(ARG_DEPTH);
      default:  d = CNT_W'(PARM_DEPTH);
    endcase
    return d;
  endfunction

endpackage

>>> rtl/multi_stack_engine.sv
// Top level of the multi-stack engine: four LIFO stacks behind stream ports.
// Instantiates mse_ctrl and mse_datapath; depends on mse_pkg.
//
// Usage:
//   Input stream (in_*): one operation per transfer. tuser carries op and
//   stack_sel, tdata carries the token and the 32-bit push value.
//   Output stream (out_*): exactly one result per input transfer, in order.
//   Configuration (cfg_*): a write sets the error token; cfg_ready is high
//   whenever reset is released. Write it only while no operation is in flight.
// Sequencing:
//   After its input transfer an item passes through stack memory access
//   with fill count update, then result forming, each registered; the
//   result then stays valid until it transfers. The sequencer handles one
//   item at a time through capture, memory access, forming and output states,
//   so a new item is taken only after the previous result has transferred.
// Reset:
//   rst_n clears every fill count (all stacks empty) and the error token, and
//   holds in_tready and cfg_ready low. Stack contents are not cleared; only
//   written entries are ever used in a result.
// Backpressure:
//   While out_tready is low the result holds and in_tready stays low.
module multi_stack_engine
  import mse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // token[7:0], push_value[39:8]
  input  logic [4:0]  in_tuser,   // op[2:0], stack_sel[4:3]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // token_out[7:0], value_out[39:8]
  output logic [2:0]  out_tuser,  // is_empty[0], status[2:1]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  cmd_t       cmd;
  logic [7:0] token_out;
  logic [31:0] value_out;
  logic       is_empty;
  logic [1:0] status;

  assign cfg_ready = rst_n;

  mse_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  mse_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .op         (in_tuser[2:0]),
    .stack_sel  (in_tuser[4:3]),
    .token      (in_tdata[7:0]),
    .push_value (in_tdata[39:8]),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_wdata  (cfg_data),
    .token_out  (token_out),
    .value_out  (value_out),
    .is_empty   (is_empty),
    .status     (status)
  );

  assign out_tdata = {value_out, token_out};
  assign out_tuser = {status, is_empty};

  // One item in flight: an accepted transfer closes the input until its result leaves.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while an item is in flight");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while a result is pending");

  // Underflow only happens on an empty stack; overflow never on an empty one.
  a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser[2:1] == ST_UNDERFLOW)) |-> out_tuser[0])
    else $error("underflow reported on a non-empty stack");

  a_overflow_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser[2:1] == ST_OVERFLOW)) |-> !out_tuser[0])
    else $error("overflow reported on an empty stack");

endmodule

>>> rtl/mse_ctrl.sv
// Controller of the multi-stack engine: one-hot sequencer that steps each
// item through capture, execute, result forming and output hand-off.
// Depends on mse_pkg.
module mse_ctrl
  import mse_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  output logic out_tvalid,
  input  logic out_tready,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_FORM = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: state_nxt = S_FORM;
      S_FORM: state_nxt = S_OUT;
      S_OUT: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // The input stays closed while reset is held.
  assign in_tready     = (state_r == S_IDLE) && rst_n;
  assign out_tvalid    = (state_r == S_OUT);
  assign cmd.load_item = in_tready && in_tvalid;
  assign cmd.exec      = (state_r == S_EXEC);
  assign cmd.form      = (state_r == S_FORM);

endmodule

>>> rtl/mse_datapath.sv
// Datapath of the multi-stack engine: item registers, fill counters, the
// four stack memories, the error token register and the result register.
// Depends on mse_pkg; driven by commands from mse_ctrl.
module mse_datapath
  import mse_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  input  logic [2:0]       op,
  input  logic [1:0]       stack_sel,
  input  logic [TOK_W-1:0] token,
  input  logic [VAL_W-1:0] push_value,
  input  logic             cfg_we,
  input  logic [TOK_W-1:0] cfg_wdata,
  output logic [TOK_W-1:0] token_out,
  output logic [VAL_W-1:0] value_out,
  output logic             is_empty,
  output logic [1:0]       status
);

  logic [2:0]       op_r;
  logic [1:0]       sel_r;
  logic [TOK_W-1:0] tok_r;
  logic [VAL_W-1:0] val_r;
  logic [TOK_W-1:0] err_tok_r;

  cnt_t fill_r [4];

  logic [CALC_W-1:0] calc_mem [CALC_DEPTH];
  logic [TOK_W-1:0]  oper_mem [OPER_DEPTH];
  logic [TOK_W-1:0]  arg_mem  [ARG_DEPTH];
  logic [TOK_W-1:0]  parm_mem [PARM_DEPTH];

  logic [CALC_W-1:0] calc_rd_r;
  logic [TOK_W-1:0]  oper_rd_r, arg_rd_r, parm_rd_r;

  logic       empty_r, rd_ok_r;
  logic [1:0] status_r;

  logic [TOK_W-1:0] token_out_r;
  logic [VAL_W-1:0] value_out_r;
  logic             is_empty_r;
  logic [1:0]       status_out_r;

  cnt_t cnt, dep, top;
  logic empty, full, rd_ok, do_push, do_pop, is_rd_op;
  logic [1:0] status_nxt;
  logic [TOK_W-1:0] byte_rd;

  always_comb begin
    cnt      = fill_r[sel_r];
    dep      = depth_of(sel_r);
    top      = cnt - CNT_W'(1);
    empty    = (cnt == '0);
    full     = (cnt >= dep);
    rd_ok    = !empty && (cnt <= dep);
    is_rd_op = (op_r == OP_POP) || (op_r == OP_PEEK);
    do_push  = (op_r == OP_PUSH) && !full;
    do_pop   = (op_r == OP_POP) && rd_ok;
    status_nxt = ST_OK;
    if ((op_r == OP_PUSH) && full) status_nxt = ST_OVERFLOW;
    if ((op_r == OP_POP) && !rd_ok) status_nxt = ST_UNDERFLOW;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_tok_r <= '0;
    end else if (cfg_we) begin
      err_tok_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r  <= op;
      sel_r <= stack_sel;
      tok_r <= token;
      val_r <= push_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) fill_r[i] <= '0;
    end else if (cmd.exec) begin
      if (op_r == OP_CLEAR) begin
        for (int i = 0; i < 4; i++) fill_r[i] <= '0;
      end else if (do_push) begin
        fill_r[sel_r] <= cnt + CNT_W'(1);
      end else if (do_pop) begin
        fill_r[sel_r] <= top;
      end
    end
  end

  // Each memory is read at the current top and written at the next free slot.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      calc_rd_r <= calc_mem[top[CALC_AW-1:0]];
      if (do_push && (sel_r == SEL_CALC)) calc_mem[cnt[CALC_AW-1:0]] <= {tok_r, val_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      oper_rd_r <= oper_mem[top[OPER_AW-1:0]];
      if (do_push && (sel_r == SEL_OPER)) oper_mem[cnt[OPER_AW-1:0]] <= tok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      arg_rd_r <= arg_mem[top[ARG_AW-1:0]];
      if (do_push && (sel_r == SEL_ARG)) arg_mem[cnt[ARG_AW-1:0]] <= tok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      parm_rd_r <= parm_mem[top[PARM_AW-1:0]];
      if (do_push && (sel_r == SEL_PARM)) parm_mem[cnt[PARM_AW-1:0]] <= tok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      empty_r  <= empty;
      rd_ok_r  <= rd_ok;
      status_r <= status_nxt;
    end
  end

  always_comb begin
    case (sel_r)
      SEL_CALC: byte_rd = calc_rd_r[CALC_W-1:VAL_W];
      SEL_OPER: byte_rd = oper_rd_r;
      SEL_ARG:  byte_rd = arg_rd_r;
      default:  byte_rd = parm_rd_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.form) begin
      if (is_rd_op) begin
        token_out_r <= rd_ok_r ? byte_rd : err_tok_r;
      end else begin
        token_out_r <= '0;
      end
      if ((op_r == OP_POP) && (sel_r == SEL_CALC) && rd_ok_r) begin
        value_out_r <= calc_rd_r[VAL_W-1:0];
      end else begin
        value_out_r <= '0;
      end
      is_empty_r   <= empty_r;
      status_out_r <= status_r;
    end
  end

  assign token_out = token_out_r;
  assign value_out = value_out_r;
  assign is_empty  = is_empty_r;
  assign status    = status_out_r;

endmodule
